// ----- hw/rtl/aes_block_cipher_assert.svh -----
// Assertion macros for the AES block cipher RTL.
`ifndef AES_BLOCK_CIPHER_ASSERT_SVH
`define AES_BLOCK_CIPHER_ASSERT_SVH
`ifndef SYNTHESIS
`define AES_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("aes assertion failed");
`define AES_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("aes forbidden condition");
`else
`define AES_ASSERT(lbl, prop)
`define AES_NEVER(lbl, cond)
`endif
`endif

// ----- hw/rtl/aes_pkg.sv -----
// Shared types, register codes, S-box tables and round functions for the AES core.
package aes_pkg;

	typedef struct packed {
		logic [63:0] block_high;
		logic [63:0] block_low;
	} blk_t;

	typedef struct packed {
		logic [63:0] result_high;
		logic [63:0] result_low;
	} res_t;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_KEY0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KLEN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DEC  = 3'd4;

	localparam logic [1:0] STEP_ADD  = 2'd0;
	localparam logic [1:0] STEP_MID  = 2'd1;
	localparam logic [1:0] STEP_LAST = 2'd2;

	typedef struct packed {
		logic       load_blk;
		logic       exp_en;
		logic       step_en;
		logic [1:0] step_kind;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic       key_wr;
		logic       dec;
		logic [3:0] nr;
	} status_t;

	typedef logic [7:0] byte_tab_t [256];

	localparam byte_tab_t SBOX = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic byte_tab_t build_inv();
		byte_tab_t t;
		for (int i = 0; i < 256; i++) begin
			t[SBOX[i]] = 8'(i);
		end
		return t;
	endfunction

	localparam byte_tab_t INV_SBOX = build_inv();

	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	// byte i of the state sits at bits 127-8i downward
	function automatic logic [127:0] sub_shift(input logic [127:0] v);
		logic [127:0] o;
		o = '0;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				o[127-8*(c*4+r) -: 8] = SBOX[v[127-8*(((c+r)%4)*4+r) -: 8]];
			end
		end
		return o;
	endfunction

	function automatic logic [127:0] inv_sub_shift(input logic [127:0] v);
		logic [127:0] o;
		o = '0;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				o[127-8*(((c+r)%4)*4+r) -: 8] = INV_SBOX[v[127-8*(c*4+r) -: 8]];
			end
		end
		return o;
	endfunction

	function automatic logic [127:0] mix(input logic [127:0] v);
		logic [127:0] o;
		logic [7:0] a0, a1, a2, a3;
		o = '0;
		for (int c = 0; c < 4; c++) begin
			a0 = v[127-32*c -: 8];
			a1 = v[119-32*c -: 8];
			a2 = v[111-32*c -: 8];
			a3 = v[103-32*c -: 8];
			o[127-32*c -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
			o[119-32*c -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
			o[111-32*c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
			o[103-32*c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
		end
		return o;
	endfunction

	// products by 9, 11, 13, 14 from doubled terms
	function automatic logic [31:0] gm_set(input logic [7:0] a);
		logic [7:0] x2, x4, x8;
		x2 = xtime(a);
		x4 = xtime(x2);
		x8 = xtime(x4);
		return {x8 ^ a, x8 ^ x2 ^ a, x8 ^ x4 ^ a, x8 ^ x4 ^ x2};
	endfunction

	function automatic logic [127:0] inv_mix(input logic [127:0] v);
		logic [127:0] o;
		logic [31:0] g0, g1, g2, g3;
		o = '0;
		for (int c = 0; c < 4; c++) begin
			// fields: [31:24]=x9 [23:16]=xb [15:8]=xd [7:0]=xe
			g0 = gm_set(v[127-32*c -: 8]);
			g1 = gm_set(v[119-32*c -: 8]);
			g2 = gm_set(v[111-32*c -: 8]);
			g3 = gm_set(v[103-32*c -: 8]);
			o[127-32*c -: 8] = g0[7:0] ^ g1[23:16] ^ g2[15:8] ^ g3[31:24];
			o[119-32*c -: 8] = g0[31:24] ^ g1[7:0] ^ g2[23:16] ^ g3[15:8];
			o[111-32*c -: 8] = g0[15:8] ^ g1[31:24] ^ g2[7:0] ^ g3[23:16];
			o[103-32*c -: 8] = g0[23:16] ^ g1[15:8] ^ g2[31:24] ^ g3[7:0];
		end
		return o;
	endfunction

endpackage

// ----- hw/rtl/aes_ctrl.sv -----
// Sequencer for key expansion, round stepping and result hand-off.
`include "aes_block_cipher_assert.svh"
module aes_ctrl #(
	parameter int AW = 4,
	parameter int KW = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             blk_valid,
	output logic             blk_stall,
	output logic             res_valid,
	input  logic             res_stall,
	input  aes_pkg::status_t stat,
	output aes_pkg::cmd_t    cmd,
	output logic [KW-1:0]    exp_idx,
	output logic [AW-1:0]    rd_addr
);
	import aes_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_EXPAND = 3'd1;
	localparam logic [2:0] ST_FETCH  = 3'd2;
	localparam logic [2:0] ST_ROUND  = 3'd3;
	localparam logic [2:0] ST_DONE   = 3'd4;

	logic [2:0]    state_q, state_d;
	logic [KW-1:0] k_q, total;
	logic [3:0]    step_q, step_nxt, key_step;
	logic          sched_valid_q, res_valid_q, accept, out_free;

	assign accept    = blk_valid && !blk_stall;
	assign blk_stall = (state_q != ST_IDLE);
	assign res_valid = res_valid_q;
	assign out_free  = !res_valid_q || !res_stall;
	assign total     = KW'((32'(stat.nr) + 32'd1) * 32'd4);
	assign exp_idx   = k_q;
	assign step_nxt  = (step_q == stat.nr) ? step_q : step_q + 4'd1;

	always_comb begin
		key_step = (state_q == ST_ROUND) ? step_nxt : 4'd0;
		rd_addr  = AW'(stat.dec ? (stat.nr - key_step) : key_step);
	end

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		cmd.step_kind = STEP_ADD;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.load_blk = 1'b1;
					state_d = sched_valid_q ? ST_FETCH : ST_EXPAND;
				end
			end
			ST_EXPAND: begin
				cmd.exp_en = 1'b1;
				if (k_q == total - KW'(1)) state_d = ST_FETCH;
			end
			ST_FETCH: state_d = ST_ROUND;
			ST_ROUND: begin
				cmd.step_en = 1'b1;
				if (step_q == 4'd0) cmd.step_kind = STEP_ADD;
				else if (step_q == stat.nr) cmd.step_kind = STEP_LAST;
				else cmd.step_kind = STEP_MID;
				if (step_q == stat.nr) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			k_q           <= '0;
			step_q        <= '0;
			sched_valid_q <= 1'b0;
			res_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) k_q <= '0;
			else if (state_q == ST_EXPAND) k_q <= k_q + KW'(1);
			if (state_q == ST_FETCH) step_q <= '0;
			else if (state_q == ST_ROUND) step_q <= step_nxt;
			if (stat.key_wr) sched_valid_q <= 1'b0;
			else if (state_q == ST_EXPAND && state_d == ST_FETCH) sched_valid_q <= 1'b1;
			if (cmd.out_load) res_valid_q <= 1'b1;
			else if (!res_stall) res_valid_q <= 1'b0;
		end
	end

	`AES_ASSERT(a_round_needs_sched, (state_q == ST_ROUND) |-> sched_valid_q)
	`AES_ASSERT(a_accept_leaves_idle, accept |=> (state_q != ST_IDLE))
	`AES_ASSERT(a_step_in_range, (state_q == ST_ROUND) |-> (step_q <= stat.nr))
	`AES_NEVER(a_no_overwrite, cmd.out_load && res_valid_q && res_stall)

endmodule

// ----- hw/rtl/aes_dp.sv -----
// Datapath: config registers, key expansion, round-key memory and round logic.
module aes_dp #(
	parameter int MAX_ROUNDS = 12,
	parameter int AW = 4,
	parameter int KW = 6
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [aes_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                   cfg_data,
	input  aes_pkg::blk_t                 blk_data,
	output aes_pkg::res_t                 res_data,
	input  aes_pkg::cmd_t                 cmd,
	input  logic [KW-1:0]                 exp_idx,
	input  logic [AW-1:0]                 rd_addr,
	output aes_pkg::status_t              stat
);
	import aes_pkg::*;

	localparam int DEPTH = MAX_ROUNDS + 1;

	logic [63:0]  key0_q, key1_q, key2_q;
	logic         klen_q, dec_q, key_wr;
	logic [127:0] mem [DEPTH];
	logic [127:0] rk_q, st_q, res_q, st_d, rk_im;
	logic [31:0]  win_q [6];
	logic [95:0]  row_q;
	logic [7:0]   rc_q, rc_cur;
	logic [2:0]   mod_q, mod_cur, nk;
	logic [31:0]  word, t, key_in;
	logic [3:0]   nr_full;

	// config decode
	always_comb begin
		key_wr = 1'b0;
		if (cfg_we) begin
			unique case (cfg_index) inside
				REG_KEY0, REG_KEY1, REG_KEY2, REG_KLEN: key_wr = 1'b1;
				default: key_wr = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key0_q <= '0;
			key1_q <= '0;
			key2_q <= '0;
			klen_q <= 1'b0;
			dec_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KEY0: key0_q <= cfg_data;
				REG_KEY1: key1_q <= cfg_data;
				REG_KEY2: key2_q <= cfg_data;
				REG_KLEN: klen_q <= cfg_data[0];
				REG_DEC:  dec_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign nr_full     = klen_q ? 4'd12 : 4'd10;
	assign stat.nr     = (32'(nr_full) > MAX_ROUNDS) ? 4'(MAX_ROUNDS) : nr_full;
	assign stat.dec    = dec_q;
	assign stat.key_wr = key_wr;

	// key expansion, one 32-bit word per cycle
	assign nk      = klen_q ? 3'd6 : 3'd4;
	assign mod_cur = (exp_idx == '0) ? 3'd0 : mod_q;
	assign rc_cur  = (exp_idx == '0) ? 8'h01 : rc_q;

	always_comb begin
		case (exp_idx[2:0])
			3'd0: key_in = key0_q[63:32];
			3'd1: key_in = key0_q[31:0];
			3'd2: key_in = key1_q[63:32];
			3'd3: key_in = key1_q[31:0];
			3'd4: key_in = key2_q[63:32];
			default: key_in = key2_q[31:0];
		endcase
		t = win_q[0];
		if (mod_cur == 3'd0) t = sub_word({t[23:0], t[31:24]}) ^ {rc_cur, 24'h0};
		if (exp_idx < KW'(nk)) word = key_in;
		else word = (klen_q ? win_q[5] : win_q[3]) ^ t;
	end

	always_ff @(posedge clk) begin
		if (cmd.exp_en) begin
			win_q[0] <= word;
			for (int i = 1; i < 6; i++) win_q[i] <= win_q[i-1];
			row_q  <= {row_q[63:0], word};
			mod_q  <= (mod_cur == nk - 3'd1) ? 3'd0 : mod_cur + 3'd1;
			rc_q   <= (exp_idx >= KW'(nk) && mod_cur == 3'd0) ? xtime(rc_cur) : rc_cur;
			if (exp_idx[1:0] == 2'd3) mem[exp_idx[KW-1:2]] <= {row_q, word};
		end
		rk_q <= mem[rd_addr];
	end

	// round step
	assign rk_im = inv_mix(rk_q);

	always_comb begin
		case (cmd.step_kind)
			STEP_MID:  st_d = dec_q ? (inv_mix(inv_sub_shift(st_q)) ^ rk_im)
			                        : (mix(sub_shift(st_q)) ^ rk_q);
			STEP_LAST: st_d = (dec_q ? inv_sub_shift(st_q) : sub_shift(st_q)) ^ rk_q;
			default:   st_d = st_q ^ rk_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load_blk) st_q <= blk_data;
		else if (cmd.step_en) st_q <= st_d;
		if (cmd.out_load) res_q <= st_q;
	end

	assign res_data = res_q;

endmodule

// ----- hw/rtl/aes_block_cipher.sv -----
// AES-128/192 block cipher top level: iterative core, one round per cycle.
// An accepted word passes the key fetch, round and done states before result valid rises,
// and the first word after a key write first waits for key expansion.
// One word at a time: the next is taken once the last result is loaded (single round unit).
// The next word is taken while a finished result still waits in the output register.
// Reset: arst_n clears config registers, controller state and the schedule flag.
module aes_block_cipher #(
	parameter int MAX_ROUNDS = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          blk_valid,
	output logic                          blk_stall,
	input  aes_pkg::blk_t                 blk_data,
	output logic                          res_valid,
	input  logic                          res_stall,
	output aes_pkg::res_t                 res_data,
	input  logic                          cfg_we,
	input  logic [aes_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                   cfg_data
);
	import aes_pkg::*;

	// round-key memory: one 128-bit row per round key
	localparam int AW = $clog2(MAX_ROUNDS + 1);
	// expansion word counter covers 4*(Nr+1) words
	localparam int KW = AW + 2;

	cmd_t          cmd;
	status_t       stat;
	logic [KW-1:0] exp_idx;
	logic [AW-1:0] rd_addr;

	// controller: sequences expansion, key fetch, rounds, output hand-off
	aes_ctrl #(.AW(AW), .KW(KW)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.blk_valid (blk_valid),
		.blk_stall (blk_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.stat      (stat),
		.cmd       (cmd),
		.exp_idx   (exp_idx),
		.rd_addr   (rd_addr)
	);

	// datapath: state register, round logic, key schedule and memory
	aes_dp #(.MAX_ROUNDS(MAX_ROUNDS), .AW(AW), .KW(KW)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.blk_data  (blk_data),
		.res_data  (res_data),
		.cmd       (cmd),
		.exp_idx   (exp_idx),
		.rd_addr   (rd_addr),
		.stat      (stat)
	);

endmodule

// ----- tb/aes_block_cipher_tb.sv -----
// Testbench for the AES-128/192 block cipher: predicted results against the core's output words.
`timescale 1ns / 100ps

module aes_block_cipher_tb;
	import aes_pkg::*;

	localparam int CLK_PERIOD = 10;
	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_ROUNDS = 12;
	localparam int RANDOM_ITEMS = 1250;
	localparam int LONG_HOLD = 150;
	// longest accept-to-result time: 192-bit expansion plus 12 rounds plus load
	localparam int DRAIN_CYCLES = 4 * 13 + 15 + 10;

	typedef logic [7:0] sbox_t [256];

	logic clk;
	logic arst_n;
	logic blk_valid;
	logic blk_stall;
	blk_t blk_data;
	logic res_valid;
	logic res_stall;
	res_t res_data;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [63:0] cfg_data;

	aes_block_cipher #(.MAX_ROUNDS(MAX_ROUNDS)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.blk_valid(blk_valid),
		.blk_stall(blk_stall),
		.blk_data(blk_data),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_data(res_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Predictor state: its own copy of the key registers and the schedule
	sbox_t fwd_box;
	sbox_t rev_box;
	logic [63:0] key_w0, key_w1, key_w2;
	logic klen_192;
	logic dec_on;
	logic [31:0] sched [4*(MAX_ROUNDS+1)];
	logic sched_ok;

	blk_t pending_words[$];
	res_t expected_results[$];
	int errors;
	int cycles;
	logic long_hold;
	logic feed_pause;
	logic blk_stall_q;

	function automatic logic [7:0] dbl(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		p = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) p ^= a;
			a = dbl(a);
		end
		return p;
	endfunction

	function automatic logic [7:0] byte_at(input logic [127:0] s, input int i);
		return s[127-8*i -: 8];
	endfunction

	function automatic logic [127:0] col_mix(input logic [127:0] s, input logic inverse);
		logic [127:0] o;
		logic [7:0] a [4];
		logic [7:0] m [4];
		o = '0;
		if (inverse) m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
		else m = '{8'h02, 8'h03, 8'h01, 8'h01};
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) a[r] = byte_at(s, 4*c+r);
			for (int r = 0; r < 4; r++) begin
				o[127-8*(4*c+r) -: 8] = gf_mul(a[0], m[(4-r)%4]) ^ gf_mul(a[1], m[(5-r)%4])
					^ gf_mul(a[2], m[(6-r)%4]) ^ gf_mul(a[3], m[(7-r)%4]);
			end
		end
		return o;
	endfunction

	function automatic logic [127:0] sub_rows(input logic [127:0] s, input logic inverse);
		logic [127:0] o;
		o = '0;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				if (inverse)
					o[127-8*(((c+r)%4)*4+r) -: 8] = rev_box[byte_at(s, 4*c+r)];
				else
					o[127-8*(4*c+r) -: 8] = fwd_box[byte_at(s, ((c+r)%4)*4+r)];
			end
		end
		return o;
	endfunction

	function automatic int num_rounds();
		int nr;
		nr = klen_192 ? 12 : 10;
		return nr > MAX_ROUNDS ? MAX_ROUNDS : nr;
	endfunction

	function automatic void expand_schedule();
		int nk;
		int total;
		logic [31:0] t;
		logic [7:0] rcon;
		nk = klen_192 ? 6 : 4;
		total = 4 * (num_rounds() + 1);
		rcon = 8'h01;
		foreach (sched[i]) sched[i] = '0;
		sched[0] = key_w0[63:32]; sched[1] = key_w0[31:0];
		sched[2] = key_w1[63:32]; sched[3] = key_w1[31:0];
		if (nk == 6) begin
			sched[4] = key_w2[63:32]; sched[5] = key_w2[31:0];
		end
		for (int i = nk; i < total; i++) begin
			t = sched[i-1];
			if (i % nk == 0) begin
				t = {t[23:0], t[31:24]};
				t = {fwd_box[t[31:24]], fwd_box[t[23:16]], fwd_box[t[15:8]], fwd_box[t[7:0]]};
				t ^= {rcon, 24'h0};
				rcon = dbl(rcon);
			end
			sched[i] = sched[i-nk] ^ t;
		end
		sched_ok = 1'b1;
	endfunction

	function automatic logic [127:0] round_key(input int r, input logic inv_mixed);
		logic [127:0] k;
		k = {sched[4*r], sched[4*r+1], sched[4*r+2], sched[4*r+3]};
		return inv_mixed ? col_mix(k, 1'b1) : k;
	endfunction

	function automatic res_t cipher_block(input blk_t b);
		logic [127:0] s;
		int nr;
		res_t o;
		if (!sched_ok) expand_schedule();
		nr = num_rounds();
		s = {b.block_high, b.block_low};
		if (!dec_on) begin
			s ^= round_key(0, 1'b0);
			for (int r = 1; r < nr; r++) s = col_mix(sub_rows(s, 1'b0), 1'b0) ^ round_key(r, 1'b0);
			s = sub_rows(s, 1'b0) ^ round_key(nr, 1'b0);
		end else begin
			s ^= round_key(nr, 1'b0);
			for (int r = nr - 1; r >= 1; r--)
				s = col_mix(sub_rows(s, 1'b1), 1'b1) ^ round_key(r, 1'b1);
			s = sub_rows(s, 1'b1) ^ round_key(0, 1'b0);
		end
		o.result_high = s[127:64];
		o.result_low = s[63:0];
		return o;
	endfunction

	function automatic void note_config(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] v);
		case (idx)
			REG_KEY0: begin key_w0 = v; sched_ok = 1'b0; end
			REG_KEY1: begin key_w1 = v; sched_ok = 1'b0; end
			REG_KEY2: begin key_w2 = v; sched_ok = 1'b0; end
			REG_KLEN: begin klen_192 = v[0]; sched_ok = 1'b0; end
			REG_DEC: dec_on = v[0];
			default: ;
		endcase
	endfunction

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD/2) clk = ~clk;
	end

	// Time limit and cycle count
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Driver: offers queued words at the falling edge with random gaps
	int gap_left;
	always @(negedge clk) begin
		if (arst_n) begin
			if (blk_valid && !blk_stall_q) begin
				// taken at the last rising edge
				if (gap_left == 0 && !feed_pause && pending_words.size() > 0) begin
					blk_data <= pending_words.pop_front();
					blk_valid <= 1'b1;
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
				end else begin
					blk_valid <= 1'b0;
				end
			end else if (!blk_valid) begin
				if (gap_left > 0) gap_left <= gap_left - 1;
				else if (!feed_pause && pending_words.size() > 0) begin
					blk_data <= pending_words.pop_front();
					blk_valid <= 1'b1;
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
				end
			end
		end
	end

	// Stall and acceptance as seen at the rising edge
	always @(posedge clk) begin
		blk_stall_q <= blk_stall;
		if (arst_n && blk_valid && !blk_stall)
			expected_results.push_back(cipher_block(blk_data));
	end

	// Receiver stall: random per word, plus one long hold-off counted here
	int hold_left;
	int long_left;
	logic long_done;
	always @(negedge clk) begin
		if (long_left > 0) begin
			long_left <= long_left - 1;
			res_stall <= 1'b1;
		end else if (long_hold && !long_done) begin
			long_left <= LONG_HOLD - 1;
			long_done <= 1'b1;
			res_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			res_stall <= 1'b1;
		end else begin
			res_stall <= 1'b0;
			if (res_valid) hold_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
		end
	end

	// Monitor: each accepted result against the oldest prediction
	always @(posedge clk) begin
		res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (expected_results.size() == 0) begin
				$error("result word with no prediction waiting: %h", res_data);
				errors++;
			end else begin
				want = expected_results.pop_front();
				if (res_data.result_high !== want.result_high) begin
					$error("result_high expected %h actual %h", want.result_high,
						res_data.result_high);
					errors++;
				end
				if (res_data.result_low !== want.result_low) begin
					$error("result_low expected %h actual %h", want.result_low,
						res_data.result_low);
					errors++;
				end
			end
		end
	end

	task automatic wait_idle();
		while (pending_words.size() > 0 || blk_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		note_config(idx, v);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_key(input logic [63:0] k0, input logic [63:0] k1, input logic [63:0] k2,
		input logic [63:0] klen, input logic [63:0] dec);
		write_reg(REG_KEY0, k0);
		write_reg(REG_KEY1, k1);
		write_reg(REG_KEY2, k2);
		write_reg(REG_KLEN, klen);
		write_reg(REG_DEC, dec);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic blk_t rand_block();
		blk_t b;
		case ($urandom_range(0, 9))
			0: b = '0;
			1: b = '1;
			default: b = {rand64(), rand64()};
		endcase
		return b;
	endfunction

	task automatic queue_random(input int n);
		for (int i = 0; i < n; i++) pending_words.push_back(rand_block());
	endtask

	initial begin
		int per_phase;
		for (int i = 0; i < 256; i++) fwd_box[i] = SBOX[i];
		for (int i = 0; i < 256; i++) rev_box[fwd_box[i]] = 8'(i);
		key_w0 = '0; key_w1 = '0; key_w2 = '0;
		klen_192 = 1'b0; dec_on = 1'b0; sched_ok = 1'b0;
		errors = 0; cycles = 0; gap_left = 0; hold_left = 0;
		long_left = 0; long_done = 1'b0;
		long_hold = 1'b0; feed_pause = 1'b0;
		blk_valid = 1'b0; blk_data = '0; res_stall = 1'b0;
		cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset key (all zeros), 128-bit encrypt, extreme blocks
		pending_words.push_back('0);
		pending_words.push_back('1);
		pending_words.push_back({64'h0011223344556677, 64'h8899aabbccddeeff});
		wait_idle();
		// Published test key, encrypt; key_word_2 ignored in 128-bit mode
		load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'hffffffffffffffff, 0, 0);
		pending_words.push_back({64'h0011223344556677, 64'h8899aabbccddeeff});
		pending_words.push_back({64'h8000000000000000, 64'h0000000000000001});
		wait_idle();
		// Decrypt-only change keeps the schedule; wide values use the low bit only
		write_reg(REG_DEC, 64'hffffffff_fffffffe | 64'h1);
		pending_words.push_back({64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a});
		pending_words.push_back('1);
		wait_idle();
		load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h1011121314151617,
			64'hfffffffffffffffd, 0);
		pending_words.push_back({64'h0011223344556677, 64'h8899aabbccddeeff});
		pending_words.push_back('0);
		wait_idle();
		write_reg(REG_DEC, 1);
		pending_words.push_back({64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191});
		wait_idle();
		load_key('1, '1, '1, 1, 1);
		pending_words.push_back('1);
		pending_words.push_back('0);
		wait_idle();
		// Index beyond the register list is ignored
		write_reg(CFG_IDX_W'(5), '1);
		write_reg(CFG_IDX_W'(7), '1);
		pending_words.push_back({rand64(), rand64()});
		wait_idle();

		// Long receiver hold while the sender keeps offering, filling the core
		queue_random(12);
		long_hold = 1'b1;
		wait (long_done && long_left == 0);
		long_hold = 1'b0;
		wait_idle();

		// Random phases across key lengths and directions
		per_phase = RANDOM_ITEMS / 10;
		for (int p = 0; p < 10; p++) begin
			load_key(rand64(), rand64(), rand64(), $urandom_range(0, 1), $urandom_range(0, 1));
			if (p == 4) write_reg(REG_KEY0, '0);
			queue_random(per_phase);
			// sender pause partway until everything predicted has come back
			while (pending_words.size() > per_phase - per_phase / 2) @(posedge clk);
			feed_pause = 1'b1;
			while (blk_valid || expected_results.size() > 0) @(posedge clk);
			repeat (DRAIN_CYCLES) @(posedge clk);
			// mid-phase decrypt flip leaves the key schedule intact
			write_reg(REG_DEC, $urandom_range(0, 1));
			feed_pause = 1'b0;
			wait_idle();
		end

		if (errors == 0 && expected_results.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
